@@ rtl/core/pdt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pdt_pkg;

   // Field widths
   localparam int TICK_W    = 64;
   localparam int ADDR_W    = 40;
   localparam int HASH_W    = 32;
   localparam int LEN_W     = 3;
   localparam int DELTA_W   = 16;
   localparam int SLOT_W    = 3;
   localparam int CFG_W     = 16;
   // index field wide enough for the largest table (64 entries)
   localparam int IDX_W     = 6;
   localparam logic [LEN_W-1:0] ADDR_MAX_BYTES = 3'd5;
   localparam logic [DELTA_W-1:0] DELTA_SAT = 16'hFFFF;
   localparam logic [CFG_W-1:0] BURST_RESET = 16'd12;
   localparam logic [CFG_W-1:0] RETRY_RESET = 16'd1000;

   // Result outcome codes
   typedef enum logic [1:0] {
      OUT_SKIP  = 2'd0,
      OUT_ALLOC = 2'd1,
      OUT_MATCH = 2'd2
   } outcome_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_DONE
   } state_type;

   // Request as broadcast to every cell
   typedef struct packed {
      logic [TICK_W-1:0] tick;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] addr;
      logic [HASH_W-1:0] hash;
   } req_type;

   // Search token handed from cell to cell
   typedef struct packed {
      logic              vld;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [TICK_W-1:0] hit_tick;
      logic [HASH_W-1:0] hit_hash;
      logic              free;
      logic [IDX_W-1:0]  free_idx;
      logic              have;
      logic [IDX_W-1:0]  old_idx;
      logic [TICK_W-1:0] old_tick;
   } tok_type;

   // Entry update broadcast
   typedef struct packed {
      logic             en;
      logic             alloc;
      logic [IDX_W-1:0] idx;
   } wr_type;

   // Bit mask covering the first len address bytes
   function automatic logic [ADDR_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] m;
      m = '0;
      for (int b = 0; b < 5; b++) begin
         if (LEN_W'(b) < len) begin
            m[b*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/pdt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pdt_cell #(
   parameter int CELL_IDX = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pdt_pkg::req_type req,
   input  wire pdt_pkg::tok_type tok_in,
   input  wire pdt_pkg::wr_type  wr,
   output pdt_pkg::tok_type      tok_out
);
   import pdt_pkg::*;

   localparam logic [IDX_W-1:0] ME = IDX_W'(CELL_IDX);

   logic              used_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [TICK_W-1:0] tick_ff;
   logic [HASH_W-1:0] hash_ff;
   tok_type           tok_ff;
   tok_type           tok_in_n;
   logic              match;
   logic              sel;

   // Local compare against the held request
   assign match = used_ff && (len_ff == req.len) &&
                  (((addr_ff ^ req.addr) & byte_mask(req.len)) == '0);
   assign sel   = wr.en && (wr.idx == ME);

   // Fold this entry into the passing token
   always_comb begin
      tok_in_n = tok_in;
      if (!tok_in.hit && match) begin
         tok_in_n.hit      = 1'b1;
         tok_in_n.hit_idx  = ME;
         tok_in_n.hit_tick = tick_ff;
         tok_in_n.hit_hash = hash_ff;
      end
      if (!tok_in.free && !used_ff) begin
         tok_in_n.free     = 1'b1;
         tok_in_n.free_idx = ME;
      end
      if (used_ff && (!tok_in.have || (tick_ff < tok_in.old_tick))) begin
         tok_in_n.have     = 1'b1;
         tok_in_n.old_idx  = ME;
         tok_in_n.old_tick = tick_ff;
      end
   end

   // Token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_n;
      end
   end

   // Entry state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (sel) begin
         used_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         tick_ff <= req.tick;
         hash_ff <= req.hash;
         if (wr.alloc) begin
            len_ff  <= req.len;
            addr_ff <= req.addr;
         end
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

@@ rtl/core/packet_device_tracker_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width  Contents
// req_*     in   144    tick, address_length, address, pkt_hash
// rsp_*     out  24     outcome, slot, delta_ticks, burst, retry
// csr_*     in   32     burst_limit @0x0, retry_window @0x4
//
// One request at a time: after accept the request passes the scan state,
// where the search token walks the cell chain one entry per cycle, then
// the eval and done states; the input is free again once its result is
// loaded. A skipped request goes from accept straight to the done state.
// Synchronous active-high reset empties the table and loads register defaults.
// A result waits in the output register; the next request is accepted
// while it waits, and the block stalls only before loading a new result.

module packet_device_tracker_unit #(
   parameter int DEVICES = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // tick[63:0], address_length[71:64], address[111:72], pkt_hash[143:112]
   input  wire logic [143:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // outcome[1:0], slot[4:2], delta_ticks[20:5], burst[21], retry[22], zero[23]
   output logic [23:0]        rsp_tdata,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [2:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import pdt_pkg::*;

   state_type state_ff, state_in;

   logic [CFG_W-1:0] burst_ff, window_ff;
   req_type          req_ff;
   logic             skip_ff;
   logic             start_ff;
   tok_type          hold_ff;
   logic [TICK_W-1:0] diff_ff;
   logic             gt_ff, lastnz_ff, hasheq_ff;

   logic [1:0]         rsp_outcome_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [DELTA_W-1:0] rsp_delta_ff;
   logic               rsp_burst_ff, rsp_retry_ff, rsp_vld_ff;

   logic               accept, start, latch_tok, load_rsp, in_skip;
   logic [7:0]         in_len;
   logic [LEN_W-1:0]   len_clamped;
   wr_type             wr;
   tok_type            tok [0:DEVICES];
   tok_type            inject;

   logic [1:0]         res_outcome;
   logic [IDX_W-1:0]   res_idx;
   logic [DELTA_W-1:0] res_delta;
   logic               res_burst, res_retry;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? {16'd0, window_ff} : {16'd0, burst_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff  <= BURST_RESET;
         window_ff <= RETRY_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[2]) begin
            window_ff <= csr_pwdata[CFG_W-1:0];
         end else begin
            burst_ff <= csr_pwdata[CFG_W-1:0];
         end
      end
   end

   // Request decode
   assign in_len      = req_tdata[71:64];
   assign in_skip     = (in_len == 8'd0);
   assign len_clamped = (in_len > 8'(ADDR_MAX_BYTES)) ? ADDR_MAX_BYTES : in_len[LEN_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            state_in = in_skip ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: if (tok[DEVICES].vld) begin
            state_in = ST_EVAL;
         end
         ST_EVAL: state_in = ST_DONE;
         ST_DONE: if (!rsp_vld_ff || rsp_tready) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controller outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      accept     = req_tready && req_tvalid;
      start      = accept && !in_skip;
      latch_tok  = (state_ff == ST_SCAN) && tok[DEVICES].vld;
      load_rsp   = (state_ff == ST_DONE) && (!rsp_vld_ff || rsp_tready);
      wr.en      = load_rsp && !skip_ff;
      wr.alloc   = !hold_ff.hit;
      wr.idx     = res_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start;
      end
   end

   // Held request
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.tick <= req_tdata[63:0];
         req_ff.len  <= len_clamped;
         req_ff.addr <= req_tdata[111:72];
         req_ff.hash <= req_tdata[143:112];
         skip_ff     <= in_skip;
      end
   end

   // Cell chain
   always_comb begin
      inject     = '0;
      inject.vld = start_ff;
   end
   assign tok[0] = inject;

   for (genvar g = 0; g < DEVICES; g++) begin : g_cell
      pdt_cell #(
         .CELL_IDX(g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .req     (req_ff),
         .tok_in  (tok[g]),
         .wr      (wr),
         .tok_out (tok[g+1])
      );
   end

   // Capture the finished token, then the tick difference
   always_ff @(posedge clock) begin
      if (latch_tok) begin
         hold_ff <= tok[DEVICES];
      end
      if (state_ff == ST_EVAL) begin
         diff_ff   <= req_ff.tick - hold_ff.hit_tick;
         gt_ff     <= req_ff.tick > hold_ff.hit_tick;
         lastnz_ff <= hold_ff.hit_tick != '0;
         hasheq_ff <= (hold_ff.hit_hash != '0) && (hold_ff.hit_hash == req_ff.hash);
      end
   end

   // Result fields
   always_comb begin
      res_outcome = OUT_SKIP;
      res_idx     = '0;
      res_delta   = '0;
      res_burst   = 1'b0;
      res_retry   = 1'b0;
      if (hold_ff.hit) begin
         res_outcome = OUT_MATCH;
         res_idx     = hold_ff.hit_idx;
         if (gt_ff && lastnz_ff) begin
            res_delta = (diff_ff[TICK_W-1:DELTA_W] != '0) ? DELTA_SAT
                                                          : diff_ff[DELTA_W-1:0];
            res_burst = (res_delta <= burst_ff);
         end
         res_retry = hasheq_ff && gt_ff && (diff_ff[TICK_W-1:CFG_W] == '0) &&
                     (diff_ff[CFG_W-1:0] <= window_ff);
      end else begin
         res_outcome = OUT_ALLOC;
         res_idx     = hold_ff.free ? hold_ff.free_idx : hold_ff.old_idx;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         if (skip_ff) begin
            rsp_outcome_ff <= OUT_SKIP;
            rsp_slot_ff    <= '0;
            rsp_delta_ff   <= '0;
            rsp_burst_ff   <= 1'b0;
            rsp_retry_ff   <= 1'b0;
         end else begin
            rsp_outcome_ff <= res_outcome;
            rsp_slot_ff    <= res_idx[SLOT_W-1:0];
            rsp_delta_ff   <= res_delta;
            rsp_burst_ff   <= res_burst;
            rsp_retry_ff   <= res_retry;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_retry_ff, rsp_burst_ff, rsp_delta_ff,
                        rsp_slot_ff, rsp_outcome_ff};

endmodule

`default_nettype wire

@@ tb/packet_device_tracker_unit_test.sv @@
`timescale 1ns / 1ps

module packet_device_tracker_unit_test;
   import pdt_pkg::*;

   localparam int DEVICES = 8;
   localparam int POOL = 12;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 241;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [2:0] REG_BURST_LIMIT = 3'h0;
   localparam logic [2:0] REG_RETRY_WINDOW = 3'h4;

   // One expected tracker report
   typedef struct {
      outcome_type outcome;
      logic [2:0]  slot;
      logic [15:0] delta;
      logic        burst;
      logic        retry;
   } track_report_type;

   // Device table predictor plus the queue of reports it expects
   class device_table_board;
      logic [15:0]   burst_limit;
      logic [15:0]   retry_window;
      bit            entry_used[DEVICES];
      logic [2:0]    entry_len[DEVICES];
      logic [39:0]   entry_addr[DEVICES];
      logic [63:0]   entry_tick[DEVICES];
      logic [31:0]   entry_hash[DEVICES];
      track_report_type expected_reports[$];
      int            errors;
      int            checked;

      function new();
         burst_limit = BURST_RESET;
         retry_window = RETRY_RESET;
         errors = 0;
         checked = 0;
         for (int i = 0; i < DEVICES; i++) begin
            entry_used[i] = 1'b0;
            entry_len[i] = '0;
            entry_addr[i] = '0;
            entry_tick[i] = '0;
            entry_hash[i] = '0;
         end
      endfunction

      function void set_limits(logic [15:0] burst, logic [15:0] retry);
         burst_limit = burst;
         retry_window = retry;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      // Predict the report of one accepted request and update the table
      function void note_packet(logic [143:0] data);
         logic [63:0]   tick;
         logic [7:0]    len_in;
         logic [39:0]   pkt_addr;
         logic [31:0]   hash;
         logic [2:0]    len;
         logic [40:0]   wide_mask;
         logic [39:0]   mask;
         logic [63:0]   last;
         logic [63:0]   gap;
         int            hit;
         int            victim;
         track_report_type r;
         tick = data[63:0];
         len_in = data[71:64];
         pkt_addr = data[111:72];
         hash = data[143:112];
         r = '{OUT_SKIP, 3'd0, 16'd0, 1'b0, 1'b0};
         if (len_in != 8'd0) begin
            len = (len_in > 8'd5) ? 3'd5 : len_in[2:0];
            wide_mask = (41'd1 << (8 * len)) - 41'd1;
            mask = wide_mask[39:0];
            hit = -1;
            for (int i = 0; i < DEVICES; i++) begin
               if (hit < 0 && entry_used[i] && entry_len[i] == len &&
                   ((entry_addr[i] ^ pkt_addr) & mask) == 40'd0) begin
                  hit = i;
               end
            end
            if (hit < 0) begin
               // lowest free slot, else oldest tick with ties to the lowest index
               victim = -1;
               for (int i = 0; i < DEVICES; i++) begin
                  if (victim < 0 && !entry_used[i]) victim = i;
               end
               if (victim < 0) begin
                  victim = 0;
                  for (int i = 1; i < DEVICES; i++) begin
                     if (entry_tick[i] < entry_tick[victim]) victim = i;
                  end
               end
               entry_used[victim] = 1'b1;
               entry_len[victim] = len;
               entry_addr[victim] = pkt_addr;
               entry_tick[victim] = tick;
               entry_hash[victim] = hash;
               r.outcome = OUT_ALLOC;
               r.slot = 3'(victim);
            end else begin
               last = entry_tick[hit];
               gap = tick - last;
               r.outcome = OUT_MATCH;
               r.slot = 3'(hit);
               if (last != 64'd0 && tick > last) begin
                  r.delta = (gap > 64'hFFFF) ? 16'hFFFF : gap[15:0];
                  r.burst = (r.delta <= burst_limit);
               end
               // retry only needs a newer tick, not a nonzero stored one
               if (entry_hash[hit] != 32'd0 && entry_hash[hit] == hash && tick > last &&
                   gap <= {48'd0, retry_window}) begin
                  r.retry = 1'b1;
               end
               entry_tick[hit] = tick;
               entry_hash[hit] = hash;
            end
         end
         expected_reports.push_back(r);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch in %s at result %0d: got %0h, expected %0h",
                  what, checked, got, want);
         errors++;
      endtask

      // Compare one accepted result with the oldest prediction
      task check_report(logic [23:0] data);
         track_report_type e;
         if (expected_reports.size() == 0) begin
            report("unexpected result", 64'(data), 64'd0);
            return;
         end
         e = expected_reports.pop_front();
         if (data[1:0] != e.outcome) report("outcome", 64'(data[1:0]), 64'(e.outcome));
         if (data[4:2] != e.slot) report("slot", 64'(data[4:2]), 64'(e.slot));
         if (data[20:5] != e.delta) report("delta_ticks", 64'(data[20:5]), 64'(e.delta));
         if (data[21] != e.burst) report("burst", 64'(data[21]), 64'(e.burst));
         if (data[22] != e.retry) report("retry", 64'(data[22]), 64'(e.retry));
         checked++;
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   // tick[63:0], address_length[71:64], address[111:72], pkt_hash[143:112]
   logic [143:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // outcome[1:0], slot[4:2], delta_ticks[20:5], burst[21], retry[22], zero[23]
   logic [23:0]   rsp_tdata;
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [2:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   device_table_board board = new();
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   bit            hold_start = 1'b0;
   bit            hold_off = 1'b0;
   int            cycle_count = 0;
   logic [39:0]   pool_addr[POOL];
   logic [7:0]    pool_len[POOL];
   logic [31:0]   pool_hash[POOL];
   logic [63:0]   now_tick = 64'd1;

   packet_device_tracker_unit #(.DEVICES(DEVICES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: random stalls, checks every accepted result
   initial begin
      @(posedge clock);
      forever begin
         rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_report(rsp_tdata);
      end
   end

   // Long receiver hold-off, so the block fills up and stalls its input
   initial begin
      wait (hold_start);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // Offer one request, with random idle cycles first
   task automatic send_packet(input logic [63:0] tick, input logic [7:0] len_in,
                              input logic [39:0] pkt_addr, input logic [31:0] hash);
      logic [143:0] data;
      data = {hash, pkt_addr, len_in, tick};
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_packet(data);
   endtask

   // Two APB writes back to back; psel stays high between them
   task automatic load_settings(input logic [15:0] burst, input logic [15:0] retry);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_BURST_LIMIT;
      csr_pwdata <= {16'd0, burst};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_paddr <= REG_RETRY_WINDOW;
      csr_pwdata <= {16'd0, retry};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.set_limits(burst, retry);
   endtask

   // Wait until every expected result is in, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DEVICES + 8) @(posedge clock);
   endtask

   function automatic logic [39:0] random_addr();
      return {8'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [63:0] random_tick();
      return {32'($urandom), 32'($urandom)};
   endfunction

   // Mostly known devices with plausible timing, some noise
   task automatic send_random_packet();
      int          k;
      int          r;
      logic [63:0] tick;
      logic [7:0]  len_in;
      logic [39:0] pkt_addr;
      logic [39:0] keep;
      logic [40:0] wide_keep;
      logic [31:0] hash;
      r = $urandom_range(99);
      k = $urandom_range(POOL - 1);
      if (r < 4) begin
         // skipped packet with random content
         tick = random_tick();
         len_in = 8'd0;
         pkt_addr = random_addr();
         hash = $urandom;
      end else if (r < 9) begin
         tick = random_tick();
         len_in = 8'($urandom);
         pkt_addr = random_addr();
         hash = $urandom;
      end else begin
         if (r < 13) begin
            pool_addr[k] = random_addr();
            pool_len[k] = 8'($urandom_range(5, 1));
            pool_hash[k] = $urandom;
         end
         case ($urandom_range(19))
            0: now_tick = $urandom_range(1) ? random_tick() : 64'($urandom_range(3));
            1: now_tick = now_tick - 64'($urandom_range(40));
            2, 3: now_tick = now_tick + 64'($urandom_range(120000, 1000));
            4, 5, 6, 7: now_tick = now_tick + 64'($urandom_range(1500));
            default: now_tick = now_tick + 64'($urandom_range(24));
         endcase
         tick = now_tick;
         len_in = pool_len[k];
         if (len_in == 8'd5 && $urandom_range(1) == 1) len_in = 8'($urandom_range(255, 6));
         // bytes beyond the address length are free to change
         wide_keep = (41'd1 << (8 * pool_len[k])) - 41'd1;
         keep = wide_keep[39:0];
         pkt_addr = (pool_addr[k] & keep) | (random_addr() & ~keep);
         case ($urandom_range(9))
            0, 1: hash = 32'd0;
            2: begin
               pool_hash[k] = $urandom;
               hash = pool_hash[k];
            end
            default: hash = pool_hash[k];
         endcase
      end
      send_packet(tick, len_in, pkt_addr, hash);
   endtask

   // Main sequence
   initial begin
      int phase_burst[PHASES];
      int phase_retry[PHASES];
      phase_burst = '{12, 0, 65535, -1, 1, 20, -1, 65535};
      phase_retry = '{1000, 0, 65535, -1, 1, 3000, -1, 0};
      for (int i = 0; i < POOL; i++) begin
         pool_addr[i] = random_addr();
         pool_len[i] = 8'($urandom_range(5, 1));
         pool_hash[i] = $urandom;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset register values, empty table
      send_packet('1, 8'd0, '1, '1);                              // skipped
      send_packet(64'd100, 8'd3, 40'h00_0033_2211, 32'h1234);     // alloc slot 0
      send_packet(64'd105, 8'd3, 40'h5A_7733_2211, 32'h1234);     // hit, burst, retry
      send_packet(64'd2000, 8'd3, 40'h00_0033_2211, 32'h1234);    // outside window
      send_packet(64'd1990, 8'd3, 40'h00_0033_2211, 32'h1234);    // tick went back
      send_packet(64'd0, 8'd200, '1, 32'd0);                      // clamped length
      send_packet(64'd50, 8'd5, '1, 32'd0);                       // hit, stored tick zero
      send_packet(64'd0, 8'd1, 40'd0, 32'hDEAD_BEEF);             // alloc slot 2
      send_packet(64'd7, 8'd1, 40'hAB_CDEF_1200, 32'hDEAD_BEEF);  // retry without delta
      send_packet(64'd1, 8'd2, 40'h1234, 32'd5);                  // alloc slot 3
      send_packet(64'd70001, 8'd2, 40'h1234, 32'd5);              // delta saturates
      send_packet(64'd70001, 8'd2, 40'h1234, 32'd5);              // equal tick
      send_packet(64'd70013, 8'd2, 40'h1234, 32'd5);              // delta at burst limit
      send_packet(64'd80000, 8'd2, 40'h2211, 32'd7);              // same bytes, other length
      send_packet(64'd5, 8'd4, 40'h00_1111_1111, 32'd0);          // fill the table
      send_packet(64'd5, 8'd4, 40'h00_2222_2222, 32'd0);
      send_packet(64'd5, 8'd4, 40'h00_3333_3333, 32'd0);
      send_packet(64'd3000, 8'd4, 40'h00_4444_4444, 32'd9);       // evict, tie to lowest
      send_packet(64'd3001, 8'd4, 40'h00_5555_5555, 32'd9);       // evict next of the tie
      send_packet('1, 8'd3, 40'h00_0033_2211, 32'h1234);          // largest tick
      send_packet(64'd71013, 8'd2, 40'h1234, 32'd5);              // gap equals window
      send_packet(64'd72014, 8'd2, 40'h1234, 32'd5);              // gap one past window
      drain();

      // Random phases, each with its own limits and idling
      for (int p = 0; p < PHASES; p++) begin
         load_settings((phase_burst[p] < 0) ? 16'($urandom) : 16'(phase_burst[p]),
                       (phase_retry[p] < 0) ? 16'($urandom) : 16'(phase_retry[p]));
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 48;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 48;
            end
            default: begin
               send_idle_pct = 37;
               recv_stall_pct = 37;
            end
         endcase
         if (p == 4) hold_start = 1'b1;
         repeat (ITEMS_PER_PHASE) send_random_packet();
         drain();
      end

      if (board.pending() != 0) begin
         board.report("leftover expectations", 64'(board.pending()), 64'd0);
      end
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/pdt_pkg.sv
rtl/core/pdt_cell.sv
rtl/core/packet_device_tracker_unit.sv
tb/packet_device_tracker_unit_test.sv
